// ===== hw/rtl/assert_macros.svh =====
// Assertion macros used by the core RTL file to check its own behavior.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks that cons holds in the same cycle whenever ante holds.
`define WHFE_ASSERT_IMP(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Checks that cons holds in the cycle after ante holds.
`define WHFE_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hw/rtl/whfe_pkg.sv =====
// Types and constants shared by the 802.11 header field extractor.
package whfe_pkg;

  localparam int MAX_SSID_BYTES = 32;
  localparam int MAX_ELEMENTS   = 6;
  localparam int SSID_AW        = $clog2(MAX_SSID_BYTES);
  localparam int BANK_AW        = SSID_AW + 1;
  localparam int ELEM_CW        = $clog2(MAX_ELEMENTS + 1);

  localparam logic [11:0] POS_MAX = 12'hFFF;

  localparam logic [1:0] TYPE_MGMT = 2'd0;
  localparam logic [1:0] TYPE_CTRL = 2'd1;
  localparam logic [1:0] TYPE_DATA = 2'd2;
  localparam logic [1:0] TYPE_EXT  = 2'd3;

  localparam logic [3:0] SUB_PROBE_RESP = 4'd5;
  localparam logic [3:0] SUB_BEACON     = 4'd8;

  localparam logic [7:0] EID_SSID    = 8'd0;
  localparam logic [7:0] EID_CHANNEL = 8'd3;

  localparam logic [2:0] DIR_NONE   = 3'd0;
  localparam logic [2:0] DIR_ADHOC  = 3'd1;
  localparam logic [2:0] DIR_TO_STA = 3'd2;
  localparam logic [2:0] DIR_TO_AP  = 3'd3;
  localparam logic [2:0] DIR_WDS    = 3'd4;

  localparam logic CFG_SKIP   = 1'b0;
  localparam logic CFG_OFFSET = 1'b1;

  typedef enum logic [2:0] {
    PH_IDLE,
    PH_ID,
    PH_LEN,
    PH_BODY,
    PH_CHAN,
    PH_DONE
  } walk_phase_t;

  typedef struct packed {
    logic [1:0]  frame_type;
    logic [3:0]  frame_subtype;
    logic        protected_frame;
    logic        frame_valid;
    logic [2:0]  data_direction;
    logic [47:0] dest_addr;
    logic [47:0] src_addr;
    logic [47:0] bss_addr;
    logic [7:0]  channel;
    logic [5:0]  ssid_length;
  } frame_sum_t;

  typedef struct packed {
    logic               en;
    logic [BANK_AW-1:0] addr;
    logic [7:0]         data;
  } ssid_wr_t;

endpackage

// ===== hw/rtl/whfe_in_if.sv =====
// Byte channel carrying captured frame bytes into the extractor.
interface whfe_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] frame_byte;
  logic       frame_end;

  modport source (output valid, output frame_byte, output frame_end, input ready);
  modport sink (input valid, input frame_byte, input frame_end, output ready);
endinterface

// ===== hw/rtl/whfe_out_if.sv =====
// Result channel carrying the per-frame header fields and SSID bytes.
interface whfe_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  frame_type;
  logic [3:0]  frame_subtype;
  logic        protected_frame;
  logic        frame_valid;
  logic [2:0]  data_direction;
  logic [47:0] dest_addr;
  logic [47:0] src_addr;
  logic [47:0] bss_addr;
  logic [7:0]  channel;
  logic [5:0]  ssid_length;
  logic [7:0]  ssid_byte;
  logic        last_of_run;

  modport source (
    output valid, output frame_type, output frame_subtype, output protected_frame,
    output frame_valid, output data_direction, output dest_addr, output src_addr,
    output bss_addr, output channel, output ssid_length, output ssid_byte,
    output last_of_run, input ready
  );
  modport sink (
    input valid, input frame_type, input frame_subtype, input protected_frame,
    input frame_valid, input data_direction, input dest_addr, input src_addr,
    input bss_addr, input channel, input ssid_length, input ssid_byte,
    input last_of_run, output ready
  );
endinterface

// ===== hw/rtl/wlan_header_field_extractor_core.sv =====
// Top level of the 802.11 header field extractor: parser, summary queue, result sequencer.
// The frame channel takes one captured byte per beat, frame_end set on the last byte.
// The first descriptor_skip bytes of each frame are skipped; elements are walked from
// elements_offset for beacons and probe responses. Configuration is written through
// cfg_we, cfg_index and cfg_data. The user must write it only while the block is idle;
// the block itself does not enforce this. Input rate is one byte per cycle while the
// summary queue is not full; the parser keeps no byte in a buffer. On the final byte
// the frame summary enters a two-entry queue; the queue write and the registered SSID
// bank read lie before its first result beat. A frame gives one result beat per SSID
// byte kept, or one beat when no SSID was kept, one per cycle while result.ready holds.
// Up to two finished frames wait for the result channel; when the receiver stalls the
// output register holds its beat, and once both summary entries are taken frame.ready
// drops until the oldest run has been issued.
// Reset clears the configuration to its defaults (skip 0, offset 36), the per-frame
// parser state and the queue; no clearing pass is needed.
`include "assert_macros.svh"

module wlan_header_field_extractor_core (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [7:0]  cfg_data,
  whfe_in_if.sink     frame,
  whfe_out_if.source  result
);
  import whfe_pkg::*;

  logic       push;
  logic       pop;
  logic       q_full;
  logic       q_empty;
  logic       wr_bank;
  logic       rd_bank;
  frame_sum_t push_data;
  frame_sum_t head;
  ssid_wr_t   ssid_wr;

  whfe_front u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .frame     (frame),
    .q_full    (q_full),
    .wr_bank   (wr_bank),
    .push      (push),
    .push_data (push_data),
    .ssid_wr   (ssid_wr)
  );

  whfe_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_data),
    .pop       (pop),
    .full      (q_full),
    .empty     (q_empty),
    .head      (head),
    .wr_bank   (wr_bank),
    .rd_bank   (rd_bank)
  );

  whfe_back u_back (
    .clk     (clk),
    .rst     (rst),
    .empty   (q_empty),
    .head    (head),
    .rd_bank (rd_bank),
    .ssid_wr (ssid_wr),
    .pop     (pop),
    .result  (result)
  );

  `WHFE_ASSERT_IMP(a_no_push_when_full, clk, rst, push, !q_full,
                   "summary pushed into a full queue")
  `WHFE_ASSERT_IMP(a_no_ssid_single_beat, clk, rst,
                   result.valid && (result.ssid_length == 6'd0),
                   result.last_of_run && (result.ssid_byte == 8'd0),
                   "run without SSID is not a single zero beat")
  `WHFE_ASSERT_IMP(a_invalid_no_addr, clk, rst, result.valid && !result.frame_valid,
                   (result.dest_addr == 48'd0) && (result.src_addr == 48'd0) &&
                   (result.bss_addr == 48'd0) && (result.data_direction == DIR_NONE),
                   "invalid frame reports addresses")
  `WHFE_ASSERT_IMP(a_dir_only_data, clk, rst,
                   result.valid && (result.data_direction != DIR_NONE),
                   result.frame_type == TYPE_DATA,
                   "direction reported for a non-data frame")
  `WHFE_ASSERT_NEXT(a_pop_frees_slot, clk, rst, pop && !push, !q_full,
                    "queue still full after a run was issued")

endmodule

// ===== hw/rtl/whfe_front.sv =====
// Byte parser: header capture, element walk and SSID collection per frame.
module whfe_front (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_we,
  input  logic                 cfg_index,
  input  logic [7:0]           cfg_data,
  whfe_in_if.sink              frame,
  input  logic                 q_full,
  input  logic                 wr_bank,
  output logic                 push,
  output whfe_pkg::frame_sum_t push_data,
  output whfe_pkg::ssid_wr_t   ssid_wr
);
  import whfe_pkg::*;

  logic [7:0]         descriptor_skip;
  logic [7:0]         elements_offset;

  logic [11:0]        byte_position, byte_position_next;
  logic [15:0]        control_word, control_word_next;
  logic [47:0]        address_one, address_one_next;
  logic [47:0]        address_two, address_two_next;
  logic [47:0]        address_three, address_three_next;
  walk_phase_t        walk_phase, walk_phase_next;
  logic [7:0]         element_id, element_id_next;
  logic [5:0]         element_remaining, element_remaining_next;
  logic [ELEM_CW-1:0] element_count, element_count_next;
  logic [7:0]         channel_found, channel_found_next;
  logic [5:0]         ssid_count, ssid_count_next;
  logic               ssid_terminated, ssid_terminated_next;

  logic        take_byte;
  logic        in_hdr;
  logic        step;
  logic [11:0] hdr_pos;
  logic        start_walk;
  logic        take_ok;
  logic [7:0]  b;
  logic [1:0]  ds;

  assign b          = frame.frame_byte;
  assign frame.ready = !q_full;
  assign take_byte  = frame.valid && frame.ready;
  assign in_hdr     = (byte_position != POS_MAX) &&
                      (byte_position >= {4'd0, descriptor_skip});
  assign step       = take_byte && in_hdr;
  assign hdr_pos    = byte_position - {4'd0, descriptor_skip};
  assign take_ok    = element_count < ELEM_CW'(MAX_ELEMENTS);
  assign start_walk = (hdr_pos == {4'd0, elements_offset}) && (elements_offset >= 8'd2) &&
                      (control_word[3:2] == TYPE_MGMT) &&
                      ((control_word[7:4] == SUB_BEACON) ||
                       (control_word[7:4] == SUB_PROBE_RESP));
  assign push       = take_byte && frame.frame_end;

  always_comb begin
    walk_phase_next = walk_phase;
    if (step) begin
      case (walk_phase)
        PH_IDLE: begin
          if (start_walk) begin
            walk_phase_next = take_ok ? PH_LEN : PH_DONE;
          end
        end
        PH_ID: walk_phase_next = take_ok ? PH_LEN : PH_DONE;
        PH_LEN: begin
          if (b > 8'(MAX_SSID_BYTES)) begin
            walk_phase_next = PH_DONE;
          end else if (element_id == EID_CHANNEL) begin
            walk_phase_next = PH_CHAN;
          end else begin
            walk_phase_next = (b != 8'd0) ? PH_BODY : PH_ID;
          end
        end
        PH_BODY: begin
          if (element_remaining == 6'd1) begin
            walk_phase_next = PH_ID;
          end
        end
        PH_CHAN: walk_phase_next = PH_DONE;
        default: walk_phase_next = walk_phase;
      endcase
    end
  end

  always_comb begin
    byte_position_next     = byte_position;
    control_word_next      = control_word;
    address_one_next       = address_one;
    address_two_next       = address_two;
    address_three_next     = address_three;
    element_id_next        = element_id;
    element_remaining_next = element_remaining;
    element_count_next     = element_count;
    channel_found_next     = channel_found;
    ssid_count_next        = ssid_count;
    ssid_terminated_next   = ssid_terminated;
    ssid_wr.en             = 1'b0;
    ssid_wr.addr           = {wr_bank, ssid_count[SSID_AW-1:0]};
    ssid_wr.data           = b;

    if (take_byte && (byte_position != POS_MAX)) begin
      byte_position_next = byte_position + 12'd1;
    end

    if (step) begin
      if (hdr_pos == 12'd0) begin
        control_word_next[7:0] = b;
      end else if (hdr_pos == 12'd1) begin
        control_word_next[15:8] = b;
      end else if ((hdr_pos >= 12'd4) && (hdr_pos <= 12'd9)) begin
        address_one_next = {address_one[39:0], b};
      end else if ((hdr_pos >= 12'd10) && (hdr_pos <= 12'd15)) begin
        address_two_next = {address_two[39:0], b};
      end else if ((hdr_pos >= 12'd16) && (hdr_pos <= 12'd21)) begin
        address_three_next = {address_three[39:0], b};
      end

      case (walk_phase)
        PH_IDLE, PH_ID: begin
          if (((walk_phase == PH_ID) || start_walk) && take_ok) begin
            element_count_next = element_count + ELEM_CW'(1);
            element_id_next    = b;
          end
        end
        PH_LEN: begin
          if ((b <= 8'(MAX_SSID_BYTES)) && (element_id != EID_CHANNEL)) begin
            element_remaining_next = b[5:0];
            if (element_id == EID_SSID) begin
              ssid_count_next      = 6'd0;
              ssid_terminated_next = 1'b0;
            end
          end
        end
        PH_BODY: begin
          element_remaining_next = element_remaining - 6'd1;
          if ((element_id == EID_SSID) && !ssid_terminated) begin
            if (b == 8'd0) begin
              ssid_terminated_next = 1'b1;
            end else if (ssid_count < 6'(MAX_SSID_BYTES)) begin
              ssid_wr.en      = 1'b1;
              ssid_count_next = ssid_count + 6'd1;
            end
          end
        end
        PH_CHAN: channel_found_next = b;
        default: channel_found_next = channel_found;
      endcase
    end
  end

  // The summary reflects the state after the final byte has been taken in.
  always_comb begin
    ds                        = {control_word_next[8], control_word_next[9]};
    push_data.frame_type      = control_word_next[3:2];
    push_data.frame_subtype   = control_word_next[7:4];
    push_data.protected_frame = control_word_next[14];
    push_data.frame_valid     = control_word_next[3:2] != TYPE_EXT;
    push_data.data_direction  = DIR_NONE;
    push_data.dest_addr       = 48'd0;
    push_data.src_addr        = 48'd0;
    push_data.bss_addr        = 48'd0;
    push_data.channel         = channel_found_next;
    push_data.ssid_length     = ssid_count_next;
    case (control_word_next[3:2])
      TYPE_MGMT: begin
        push_data.dest_addr = address_one_next;
        push_data.src_addr  = address_two_next;
        push_data.bss_addr  = address_three_next;
      end
      TYPE_CTRL: push_data.dest_addr = address_one_next;
      TYPE_DATA: begin
        case (ds)
          2'd0: begin
            push_data.data_direction = DIR_ADHOC;
            push_data.dest_addr      = address_one_next;
            push_data.src_addr       = address_two_next;
            push_data.bss_addr       = address_three_next;
          end
          2'd1: begin
            push_data.data_direction = DIR_TO_STA;
            push_data.dest_addr      = address_one_next;
            push_data.src_addr       = address_three_next;
            push_data.bss_addr       = address_two_next;
          end
          2'd2: begin
            push_data.data_direction = DIR_TO_AP;
            push_data.dest_addr      = address_three_next;
            push_data.src_addr       = address_two_next;
            push_data.bss_addr       = address_one_next;
          end
          default: push_data.data_direction = DIR_WDS;
        endcase
      end
      default: push_data.data_direction = DIR_NONE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      descriptor_skip <= 8'd0;
      elements_offset <= 8'd36;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_SKIP:   descriptor_skip <= cfg_data;
        CFG_OFFSET: elements_offset <= cfg_data;
        default:    descriptor_skip <= descriptor_skip;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst || push) begin
      byte_position     <= 12'd0;
      control_word      <= 16'd0;
      address_one       <= 48'd0;
      address_two       <= 48'd0;
      address_three     <= 48'd0;
      walk_phase        <= PH_IDLE;
      element_id        <= 8'd0;
      element_remaining <= 6'd0;
      element_count     <= '0;
      channel_found     <= 8'd0;
      ssid_count        <= 6'd0;
      ssid_terminated   <= 1'b0;
    end else begin
      byte_position     <= byte_position_next;
      control_word      <= control_word_next;
      address_one       <= address_one_next;
      address_two       <= address_two_next;
      address_three     <= address_three_next;
      walk_phase        <= walk_phase_next;
      element_id        <= element_id_next;
      element_remaining <= element_remaining_next;
      element_count     <= element_count_next;
      channel_found     <= channel_found_next;
      ssid_count        <= ssid_count_next;
      ssid_terminated   <= ssid_terminated_next;
    end
  end

endmodule

// ===== hw/rtl/whfe_queue.sv =====
// Two-entry queue of frame summaries; each entry owns one SSID bank.
module whfe_queue (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 push,
  input  whfe_pkg::frame_sum_t push_data,
  input  logic                 pop,
  output logic                 full,
  output logic                 empty,
  output whfe_pkg::frame_sum_t head,
  output logic                 wr_bank,
  output logic                 rd_bank
);
  import whfe_pkg::*;

  localparam logic [1:0] Q_EMPTY = 2'd0;
  localparam logic [1:0] Q_FULL  = 2'd2;

  frame_sum_t entry [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;

  assign full    = count == Q_FULL;
  assign empty   = count == Q_EMPTY;
  assign head    = entry[rd_ptr];
  assign wr_bank = wr_ptr;
  assign rd_bank = rd_ptr;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= Q_EMPTY;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
      case ({push, pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entry[wr_ptr] <= push_data;
    end
  end

endmodule

// ===== hw/rtl/whfe_back.sv =====
// Result sequencer: SSID bank memory and the registered output stage.
module whfe_back (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 empty,
  input  whfe_pkg::frame_sum_t head,
  input  logic                 rd_bank,
  input  whfe_pkg::ssid_wr_t   ssid_wr,
  output logic                 pop,
  whfe_out_if.source           result
);
  import whfe_pkg::*;

  logic [7:0]         ssid_mem [1 << BANK_AW];
  logic [7:0]         ssid_rd;
  logic [SSID_AW-1:0] run_index;
  logic               out_valid;
  frame_sum_t         out_sum;
  logic               out_last;
  logic               issue;
  logic               last_issue;

  assign issue      = !empty && (!out_valid || result.ready);
  assign last_issue = (head.ssid_length == 6'd0) ||
                      (({1'b0, run_index} + 6'd1) == head.ssid_length);
  assign pop        = issue && last_issue;

  always_ff @(posedge clk) begin
    if (ssid_wr.en) begin
      ssid_mem[ssid_wr.addr] <= ssid_wr.data;
    end
  end

  always_ff @(posedge clk) begin
    if (issue) begin
      ssid_rd <= ssid_mem[{rd_bank, run_index}];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      run_index <= '0;
    end else if (issue) begin
      out_valid <= 1'b1;
      run_index <= last_issue ? '0 : run_index + SSID_AW'(1);
    end else if (result.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (issue) begin
      out_sum  <= head;
      out_last <= last_issue;
    end
  end

  assign result.valid           = out_valid;
  assign result.frame_type      = out_sum.frame_type;
  assign result.frame_subtype   = out_sum.frame_subtype;
  assign result.protected_frame = out_sum.protected_frame;
  assign result.frame_valid     = out_sum.frame_valid;
  assign result.data_direction  = out_sum.data_direction;
  assign result.dest_addr       = out_sum.dest_addr;
  assign result.src_addr        = out_sum.src_addr;
  assign result.bss_addr        = out_sum.bss_addr;
  assign result.channel         = out_sum.channel;
  assign result.ssid_length     = out_sum.ssid_length;
  assign result.ssid_byte       = (out_sum.ssid_length == 6'd0) ? 8'd0 : ssid_rd;
  assign result.last_of_run     = out_last;

endmodule

// ===== tb/wlan_header_field_extractor_core_tb.sv =====
`timescale 1ns / 100ps
// Self-checking testbench for the 802.11 header field extractor with a built-in frame parser model.
module wlan_header_field_extractor_core_tb;
  import whfe_pkg::*;

  localparam int STALL_LIMIT  = 3000;
  localparam int IDLE_PERCENT = 36;
  localparam int SETTLE_CYCLES = 8;

  typedef struct {
    logic [7:0] data;
    logic       last;
  } frame_beat_t;

  typedef struct packed {
    frame_sum_t sum;
    logic [7:0] ssid_byte;
    logic       last_of_run;
  } result_beat_t;

  logic       clk = 1'b0;
  logic       rst;
  logic       cfg_we;
  logic       cfg_index;
  logic [7:0] cfg_data;

  whfe_in_if  frame_if ();
  whfe_out_if result_if ();

  wlan_header_field_extractor_core DUT (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .frame     (frame_if),
    .result    (result_if)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  logic [7:0]   skip_bytes;
  logic [7:0]   ie_offset;
  logic [11:0]  hdr_pos;
  logic [15:0]  fc_word;
  logic [47:0]  addr1, addr2, addr3;
  walk_phase_t  phase;
  logic [7:0]   ie_id;
  logic [5:0]   ie_left;
  logic [2:0]   ie_count;
  logic [7:0]   chan_seen;
  logic [7:0]   ssid_mem [MAX_SSID_BYTES];
  logic [5:0]   ssid_len;
  logic         ssid_closed;

  frame_beat_t  pending_beats [$];
  result_beat_t expected_beats [$];
  logic [7:0]   frame_buf [$];
  result_beat_t want_beat;
  int           mismatches = 0;
  int           quiet_cycles = 0;
  bit           steady = 1'b0;

  function automatic void reset_frame_state();
    hdr_pos     = '0;
    fc_word     = '0;
    addr1       = '0;
    addr2       = '0;
    addr3       = '0;
    phase       = PH_IDLE;
    ie_id       = '0;
    ie_left     = '0;
    ie_count    = '0;
    chan_seen   = '0;
    ssid_len    = '0;
    ssid_closed = 1'b0;
  endfunction

  function automatic void begin_element(logic [7:0] b);
    if (ie_count >= MAX_ELEMENTS) begin
      phase = PH_DONE;
    end else begin
      ie_count++;
      ie_id = b;
      phase = PH_LEN;
    end
  endfunction

  // Advances the parser model by one accepted byte and, on the frame's last byte,
  // queues the run of result beats that the frame produces.
  function automatic void absorb_byte(logic [7:0] b, logic last);
    logic [11:0]  h;
    result_beat_t beat;
    int           run;
    if (hdr_pos < POS_MAX) begin
      if (hdr_pos >= {4'd0, skip_bytes}) begin
        h = hdr_pos - {4'd0, skip_bytes};
        if (h == 0) fc_word[7:0] = b;
        else if (h == 1) fc_word[15:8] = b;
        else if (h >= 4 && h <= 9) addr1 = {addr1[39:0], b};
        else if (h >= 10 && h <= 15) addr2 = {addr2[39:0], b};
        else if (h >= 16 && h <= 21) addr3 = {addr3[39:0], b};
        case (phase)
          PH_IDLE: begin
            if (h == {4'd0, ie_offset} && ie_offset >= 2 && fc_word[3:2] == TYPE_MGMT &&
                (fc_word[7:4] == SUB_BEACON || fc_word[7:4] == SUB_PROBE_RESP))
              begin_element(b);
          end
          PH_ID: begin_element(b);
          PH_LEN: begin
            if (b > MAX_SSID_BYTES) begin
              phase = PH_DONE;
            end else if (ie_id == EID_CHANNEL) begin
              phase = PH_CHAN;
            end else begin
              if (ie_id == EID_SSID) begin
                ssid_len    = '0;
                ssid_closed = 1'b0;
              end
              ie_left = b[5:0];
              if (b != 0) phase = PH_BODY;
              else phase = PH_ID;
            end
          end
          PH_BODY: begin
            if (ie_id == EID_SSID && !ssid_closed) begin
              if (b == 0) begin
                ssid_closed = 1'b1;
              end else if (ssid_len < MAX_SSID_BYTES) begin
                ssid_mem[ssid_len[4:0]] = b;
                ssid_len++;
              end
            end
            ie_left--;
            if (ie_left == 0) phase = PH_ID;
          end
          PH_CHAN: begin
            chan_seen = b;
            phase     = PH_DONE;
          end
          default: ;
        endcase
      end
      hdr_pos++;
    end
    if (last) begin
      beat                     = '0;
      beat.sum.frame_type      = fc_word[3:2];
      beat.sum.frame_subtype   = fc_word[7:4];
      beat.sum.protected_frame = fc_word[14];
      beat.sum.frame_valid     = (fc_word[3:2] != TYPE_EXT);
      beat.sum.data_direction  = DIR_NONE;
      case (fc_word[3:2])
        TYPE_MGMT: begin
          beat.sum.dest_addr = addr1;
          beat.sum.src_addr  = addr2;
          beat.sum.bss_addr  = addr3;
        end
        TYPE_CTRL: beat.sum.dest_addr = addr1;
        TYPE_DATA: begin
          beat.sum.data_direction = DIR_ADHOC + {1'b0, fc_word[8], fc_word[9]};
          case (beat.sum.data_direction)
            DIR_ADHOC: begin
              beat.sum.dest_addr = addr1;
              beat.sum.src_addr  = addr2;
              beat.sum.bss_addr  = addr3;
            end
            DIR_TO_STA: begin
              beat.sum.dest_addr = addr1;
              beat.sum.src_addr  = addr3;
              beat.sum.bss_addr  = addr2;
            end
            DIR_TO_AP: begin
              beat.sum.dest_addr = addr3;
              beat.sum.src_addr  = addr2;
              beat.sum.bss_addr  = addr1;
            end
            default: ;
          endcase
        end
        default: ;
      endcase
      beat.sum.channel     = chan_seen;
      beat.sum.ssid_length = ssid_len;
      run = (ssid_len != 0) ? int'(ssid_len) : 1;
      for (int k = 0; k < run; k++) begin
        beat.ssid_byte   = (ssid_len != 0) ? ssid_mem[k] : 8'h00;
        beat.last_of_run = (k == run - 1);
        expected_beats.push_back(beat);
      end
      reset_frame_state();
    end
  endfunction

  task automatic check_field(string name, logic [47:0] want, logic [47:0] got);
    if (got !== want) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      mismatches++;
    end
  endtask

  // Frame byte driver: a beat offered to the block is held until it is taken.
  always @(posedge clk) begin
    if (rst) begin
      frame_if.valid <= 1'b0;
    end else begin
      if (frame_if.valid && frame_if.ready) begin
        absorb_byte(frame_if.frame_byte, frame_if.frame_end);
        void'(pending_beats.pop_front());
      end
      if (!frame_if.valid || frame_if.ready) begin
        if (pending_beats.size() != 0 && (steady || $urandom_range(99) >= IDLE_PERCENT)) begin
          frame_if.valid      <= 1'b1;
          frame_if.frame_byte <= pending_beats[0].data;
          frame_if.frame_end  <= pending_beats[0].last;
        end else begin
          frame_if.valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst) begin
      result_if.ready <= 1'b0;
    end else begin
      if (result_if.valid && result_if.ready) begin
        if (expected_beats.size() == 0) begin
          $error("result beat arrived with no frame result outstanding");
          mismatches++;
        end else begin
          want_beat = expected_beats.pop_front();
          check_field("frame_type", 48'(want_beat.sum.frame_type),
                      48'(result_if.frame_type));
          check_field("frame_subtype", 48'(want_beat.sum.frame_subtype),
                      48'(result_if.frame_subtype));
          check_field("protected_frame", 48'(want_beat.sum.protected_frame),
                      48'(result_if.protected_frame));
          check_field("frame_valid", 48'(want_beat.sum.frame_valid),
                      48'(result_if.frame_valid));
          check_field("data_direction", 48'(want_beat.sum.data_direction),
                      48'(result_if.data_direction));
          check_field("dest_addr", want_beat.sum.dest_addr, result_if.dest_addr);
          check_field("src_addr", want_beat.sum.src_addr, result_if.src_addr);
          check_field("bss_addr", want_beat.sum.bss_addr, result_if.bss_addr);
          check_field("channel", 48'(want_beat.sum.channel), 48'(result_if.channel));
          check_field("ssid_length", 48'(want_beat.sum.ssid_length),
                      48'(result_if.ssid_length));
          check_field("ssid_byte", 48'(want_beat.ssid_byte), 48'(result_if.ssid_byte));
          check_field("last_of_run", 48'(want_beat.last_of_run),
                      48'(result_if.last_of_run));
        end
      end
      result_if.ready <= steady || ($urandom_range(99) >= IDLE_PERCENT);
    end
  end

  always @(posedge clk) begin
    if (rst || (frame_if.valid && frame_if.ready) || (result_if.valid && result_if.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("wlan_header_field_extractor_core_tb NOT OK");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic write_reg(logic idx, logic [7:0] val);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == CFG_SKIP) skip_bytes = val;
    else ie_offset = val;
  endtask

  task automatic drain();
    while (pending_beats.size() != 0 || frame_if.valid || expected_beats.size() != 0)
      @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Builds the capture descriptor and the frame control bytes, padded with random
  // bytes up to the first information element.
  task automatic start_header(logic [1:0] ftype, logic [3:0] sub, logic [7:0] fc_high);
    frame_buf.delete();
    repeat (skip_bytes) frame_buf.push_back(8'($urandom));
    frame_buf.push_back({sub, ftype, 2'($urandom)});
    frame_buf.push_back(fc_high);
    while (frame_buf.size() < int'(skip_bytes) + int'(ie_offset))
      frame_buf.push_back(8'($urandom));
  endtask

  task automatic add_element(logic [7:0] id, logic [7:0] len, int zero_at);
    frame_buf.push_back(id);
    frame_buf.push_back(len);
    for (int i = 0; i < ((len > 40) ? 40 : len); i++)
      frame_buf.push_back((i == zero_at) ? 8'h00 : 8'($urandom_range(1, 255)));
  endtask

  task automatic send_frame(bit cut);
    int keep;
    keep = cut ? int'($urandom_range(1, frame_buf.size())) : frame_buf.size();
    for (int i = 0; i < keep; i++)
      pending_beats.push_back('{frame_buf[i], i == keep - 1});
  endtask

  task automatic set_config(logic [7:0] skip, logic [7:0] offset, bit calm);
    drain();
    write_reg(CFG_SKIP, skip);
    write_reg(CFG_OFFSET, offset);
    steady = calm;
  endtask

  initial begin
    rst                  = 1'b1;
    cfg_we               = 1'b0;
    cfg_index            = CFG_SKIP;
    cfg_data             = 8'h00;
    frame_if.valid       = 1'b0;
    frame_if.frame_byte  = 8'h00;
    frame_if.frame_end   = 1'b0;
    result_if.ready      = 1'b0;
    skip_bytes           = 8'd0;
    ie_offset            = 8'd36;
    reset_frame_state();
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // A one-byte frame and a frame that stops inside the second address.
    frame_buf.delete();
    frame_buf.push_back(8'h00);
    send_frame(1'b0);
    start_header(TYPE_DATA, 4'h0, 8'h01);
    repeat (frame_buf.size() - 12) void'(frame_buf.pop_back());
    send_frame(1'b0);

    // Every distribution-system combination of a data frame, the last one protected.
    for (int i = 0; i < 4; i++) begin
      start_header(TYPE_DATA, 4'($urandom), 8'(i) | ((i == 3) ? 8'h40 : 8'h00));
      repeat (frame_buf.size() - 17) void'(frame_buf.pop_back());
      send_frame(1'b0);
    end
    start_header(TYPE_CTRL, 4'hB, 8'h40);
    repeat (frame_buf.size() - 10) void'(frame_buf.pop_back());
    send_frame(1'b0);
    start_header(TYPE_EXT, 4'hF, 8'hFF);
    repeat (frame_buf.size() - 17) void'(frame_buf.pop_back());
    send_frame(1'b0);

    // Beacon at the default element offset with an SSID and a channel element.
    start_header(TYPE_MGMT, SUB_BEACON, 8'h00);
    add_element(EID_SSID, 8'd4, -1);
    add_element(EID_CHANNEL, 8'd1, -1);
    send_frame(1'b0);

    // Elements right after frame control behind a short descriptor, with no idling.
    set_config(8'd3, 8'd2, 1'b1);
    start_header(TYPE_MGMT, SUB_BEACON, 8'h00);
    add_element(EID_SSID, 8'(MAX_SSID_BYTES), -1);
    add_element(EID_CHANNEL, 8'd1, -1);
    send_frame(1'b0);

    // Probe response: SSID cut at a zero byte, restarted, and an empty channel element.
    start_header(TYPE_MGMT, SUB_PROBE_RESP, 8'h00);
    add_element(EID_SSID, 8'd6, 2);
    add_element(8'hDD, 8'd1, -1);
    add_element(EID_SSID, 8'd3, -1);
    add_element(EID_CHANNEL, 8'd0, -1);
    frame_buf.push_back(8'd11);
    send_frame(1'b0);

    // A seventh element ends the walk before the channel is reached.
    start_header(TYPE_MGMT, SUB_BEACON, 8'h00);
    add_element(EID_SSID, 8'd2, -1);
    repeat (6) add_element(8'hDD, 8'd0, -1);
    add_element(EID_CHANNEL, 8'd1, -1);
    send_frame(1'b0);

    // An oversized element length ends the walk.
    start_header(TYPE_MGMT, SUB_BEACON, 8'h00);
    add_element(EID_SSID, 8'd3, -1);
    frame_buf.push_back(EID_SSID);
    frame_buf.push_back(8'(MAX_SSID_BYTES + 1));
    add_element(EID_CHANNEL, 8'd1, -1);
    send_frame(1'b0);

    // A management frame that is not walked, and a beacon cut at a random byte.
    start_header(TYPE_MGMT, 4'h4, 8'h40);
    add_element(EID_SSID, 8'd2, -1);
    send_frame(1'b0);
    start_header(TYPE_MGMT, SUB_BEACON, 8'h00);
    add_element(EID_SSID, 8'd10, -1);
    add_element(EID_CHANNEL, 8'd1, -1);
    send_frame(1'b1);

    // An element offset below two never starts the walk.
    set_config(8'd0, 8'd1, 1'b0);
    start_header(TYPE_MGMT, SUB_BEACON, 8'h00);
    add_element(EID_SSID, 8'd2, -1);
    send_frame(1'b0);
    drain();

    if (mismatches == 0) begin
      $display("wlan_header_field_extractor_core_tb OK");
    end else begin
      $display("wlan_header_field_extractor_core_tb NOT OK");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
+incdir+hw/rtl
hw/rtl/whfe_pkg.sv
hw/rtl/whfe_in_if.sv
hw/rtl/whfe_out_if.sv
hw/rtl/whfe_front.sv
hw/rtl/whfe_queue.sv
hw/rtl/whfe_back.sv
hw/rtl/wlan_header_field_extractor_core.sv
tb/wlan_header_field_extractor_core_tb.sv
